// File: hdl/slks_pkg.sv
// ----------------------------------------------------------------------------
// slks_pkg: shared types and constants of the keep-alive supervisor
// Mode and reply encodings, command and send codes, link bytes, and the
// structures passed between the datapath step and the top level.
// ----------------------------------------------------------------------------
package slks_pkg;

	typedef enum logic [6:0] {
		MODE_IDLE      = 7'b0000001,
		MODE_CHECK     = 7'b0000010,
		MODE_WAIT_KO   = 7'b0000100,
		MODE_WAIT_OK   = 7'b0001000,
		MODE_EXIT      = 7'b0010000,
		MODE_WAIT_TERM = 7'b0100000,
		MODE_PUBLISH   = 7'b1000000
	} mode_t;

	typedef enum logic [1:0] {
		REPLY_NONE = 2'd0,
		REPLY_KO   = 2'd1,
		REPLY_OK   = 2'd2,
		REPLY_TERM = 2'd3
	} reply_t;

	typedef enum logic [1:0] {
		CMD_RX_BYTE = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_PUBLISH = 2'd2,
		CMD_RESET   = 2'd3
	} command_t;

	localparam logic [2:0] SEND_NONE    = 3'd0;
	localparam logic [2:0] SEND_HELLO   = 3'd1;
	localparam logic [2:0] SEND_EXIT    = 3'd2;
	localparam logic [2:0] SEND_RESET   = 3'd3;
	localparam logic [2:0] SEND_PAYLOAD = 3'd4;

	localparam logic [2:0] LINK_IDLE      = 3'd0;
	localparam logic [2:0] LINK_CHECK     = 3'd1;
	localparam logic [2:0] LINK_WAIT_KO   = 3'd2;
	localparam logic [2:0] LINK_WAIT_OK   = 3'd3;
	localparam logic [2:0] LINK_EXIT      = 3'd4;
	localparam logic [2:0] LINK_WAIT_TERM = 3'd5;
	localparam logic [2:0] LINK_PUBLISH   = 3'd6;

	localparam logic [7:0]  CHAR_LF     = 8'h0A;
	localparam logic [7:0]  CHAR_CR     = 8'h0D;
	localparam logic [7:0]  CHAR_TILDE  = 8'h7E;
	localparam logic [15:0] LINE_KO     = 16'h4B4F;
	localparam logic [15:0] LINE_OK     = 16'h4F4B;
	localparam logic [23:0] PROMPT_TERM = 24'h3E3E3E;

	localparam logic [15:0] PERIOD_RESET = 16'd30000;

	typedef struct packed {
		mode_t        mode;
		reply_t       last_reply;
		logic [7:0]   line_position;
		logic [15:0]  line_start_chars;
		logic [23:0]  recent_chars;
		logic [15:0]  ticks_left;
	} sup_state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
		logic       tx_ready;
		logic [7:0] message_length;
	} sup_item_t;

	typedef struct packed {
		logic [2:0] tx_send;
		logic       message_done;
		logic [7:0] message_size;
		logic       publish_accepted;
		logic       timed_out;
		logic [2:0] link_state;
	} sup_result_t;

	function automatic logic [2:0] link_code(input mode_t m);
		logic [2:0] code;
		code = LINK_IDLE;
		unique case (m)
			MODE_IDLE:      code = LINK_IDLE;
			MODE_CHECK:     code = LINK_CHECK;
			MODE_WAIT_KO:   code = LINK_WAIT_KO;
			MODE_WAIT_OK:   code = LINK_WAIT_OK;
			MODE_EXIT:      code = LINK_EXIT;
			MODE_WAIT_TERM: code = LINK_WAIT_TERM;
			MODE_PUBLISH:   code = LINK_PUBLISH;
			default:        code = LINK_IDLE;
		endcase
		return code;
	endfunction

endpackage

// File: hdl/slks_step.sv
// ----------------------------------------------------------------------------
// slks_step: one-transaction update of the supervisor
// Combinational next-state and result logic for a single input item.
// ----------------------------------------------------------------------------
module slks_step import slks_pkg::*; #(
	parameter int LINE_POSITIONS     = 128,
	parameter int MAX_PUBLISH_LENGTH = 125
) (
	input  sup_state_t  cur,
	input  sup_item_t   item,
	input  logic [15:0] period,
	output sup_state_t  nxt,
	output sup_result_t res
);

	localparam logic [7:0] LINE_LAST   = 8'(LINE_POSITIONS);
	localparam logic [7:0] PUBLISH_MAX = 8'(MAX_PUBLISH_LENGTH);

	mode_t mode_exp;
	logic  expired;

	always_comb begin
		nxt      = cur;
		res      = '0;
		mode_exp = cur.mode;
		expired  = (cur.ticks_left == 16'd0);

		unique case (command_t'(item.command))
			CMD_RX_BYTE: begin
				if (item.rx_byte == CHAR_LF || item.rx_byte == CHAR_CR) begin
					if (cur.line_position > 8'd1) begin
						if (cur.line_start_chars == LINE_KO)
							nxt.last_reply = REPLY_KO;
						else if (cur.line_start_chars == LINE_OK)
							nxt.last_reply = REPLY_OK;
					end
					nxt.line_position = '0;
				end else if (item.rx_byte == CHAR_TILDE) begin
					if (cur.line_position > 8'd1) begin
						res.message_done = 1'b1;
						res.message_size = cur.line_position;
					end
					nxt.line_position = '0;
				end else begin
					// The prompt check looks at the three bytes stored before this one.
					if (cur.line_position > 8'd2 && cur.recent_chars == PROMPT_TERM)
						nxt.last_reply = REPLY_TERM;
					if (cur.line_position == 8'd0)
						nxt.line_start_chars = {item.rx_byte, 8'd0};
					else if (cur.line_position == 8'd1)
						nxt.line_start_chars = {cur.line_start_chars[15:8], item.rx_byte};
					nxt.recent_chars = {cur.recent_chars[15:0], item.rx_byte};
					if (cur.line_position >= LINE_LAST)
						nxt.line_position = '0;
					else
						nxt.line_position = cur.line_position + 8'd1;
				end
			end
			CMD_TICK: begin
				if (expired) begin
					res.timed_out  = 1'b1;
					nxt.ticks_left = period;
					if (cur.mode == MODE_WAIT_OK || cur.mode == MODE_WAIT_KO ||
					    cur.mode == MODE_WAIT_TERM)
						mode_exp = MODE_EXIT;
					else if (cur.mode == MODE_IDLE)
						mode_exp = MODE_CHECK;
				end else begin
					nxt.ticks_left = cur.ticks_left - 16'd1;
				end
				nxt.mode = mode_exp;
				unique case (mode_exp)
					MODE_CHECK: begin
						if (item.tx_ready) begin
							res.tx_send = SEND_HELLO;
							nxt.mode    = MODE_WAIT_KO;
						end
					end
					MODE_WAIT_KO: begin
						if (cur.last_reply == REPLY_KO) begin
							nxt.last_reply = REPLY_NONE;
							nxt.mode       = MODE_IDLE;
						end
					end
					MODE_WAIT_OK: begin
						if (cur.last_reply == REPLY_OK) begin
							nxt.last_reply = REPLY_NONE;
							nxt.mode       = MODE_IDLE;
						end
					end
					MODE_EXIT: begin
						if (item.tx_ready) begin
							res.tx_send = SEND_EXIT;
							nxt.mode    = MODE_WAIT_TERM;
						end
					end
					MODE_WAIT_TERM: begin
						// The terminal reply stays recorded after the reset sequence.
						if (cur.last_reply == REPLY_TERM && item.tx_ready) begin
							res.tx_send = SEND_RESET;
							nxt.mode    = MODE_IDLE;
						end
					end
					MODE_PUBLISH: begin
						if (item.tx_ready) begin
							res.tx_send = SEND_PAYLOAD;
							nxt.mode    = MODE_WAIT_OK;
						end else begin
							nxt.mode = MODE_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			CMD_PUBLISH: begin
				if (cur.mode == MODE_IDLE && item.message_length <= PUBLISH_MAX) begin
					nxt.ticks_left       = period;
					nxt.mode             = MODE_PUBLISH;
					res.publish_accepted = 1'b1;
				end
			end
			CMD_RESET: begin
				nxt.mode = MODE_EXIT;
			end
			default: begin
			end
		endcase

		res.link_state = link_code(nxt.mode);
	end

endmodule

// File: hdl/serial_link_keepalive_supervisor.sv
// ----------------------------------------------------------------------------
// serial_link_keepalive_supervisor: keep-alive supervisor for a serial link
// Input register, one-pass update of the supervisor state, result register.
// ----------------------------------------------------------------------------
// Usage:
// Every transaction on the s_axis channel carries one command (in tuser):
// a received link byte, a tick and service step, a publish request or a
// reset request. Each one yields exactly one result transaction on the
// m_axis channel with the send code, message and publish flags, the
// expiry flag and the link state after the command.
// The result passes through the input register and then the result
// register; one transaction is accepted every cycle, bounded only by the
// handshake of the input register and the result register.
// When the receiver stalls, the result register holds and the input
// register still takes one more transaction before s_axis_tready drops.
// Reset puts the supervisor in idle with no reply, an empty line, a zero
// tick count (the first tick expires) and a keep-alive period of 30000.
// keepalive_period_wr loads the period; write it only while no result is
// outstanding.
// ----------------------------------------------------------------------------
module serial_link_keepalive_supervisor import slks_pkg::*; #(
	parameter int LINE_POSITIONS     = 128,
	parameter int MAX_PUBLISH_LENGTH = 125
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        keepalive_period_wr,
	input  logic [15:0] keepalive_period_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] rx_byte, [8] tx_ready, [16:9] message_length, [23:17] zero
	input  logic [23:0] s_axis_tdata,
	// [1:0] command
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] tx_send, [3] message_done, [11:4] message_size,
	// [12] publish_accepted, [13] timed_out, [16:14] link_state, [23:17] zero
	output logic [23:0] m_axis_tdata
);

	logic [15:0] period_q;
	sup_state_t  state_q;
	sup_state_t  state_next;
	sup_item_t   item_s1;
	logic        valid_s1;
	sup_result_t result_next;
	sup_result_t result_s2;
	logic        valid_s2;
	logic        advance;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (keepalive_period_wr) begin
			period_q <= keepalive_period_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command        <= s_axis_tuser;
			item_s1.rx_byte        <= s_axis_tdata[7:0];
			item_s1.tx_ready       <= s_axis_tdata[8];
			item_s1.message_length <= s_axis_tdata[16:9];
		end
	end

	slks_step #(
		.LINE_POSITIONS    (LINE_POSITIONS),
		.MAX_PUBLISH_LENGTH(MAX_PUBLISH_LENGTH)
	) u_step (
		.cur   (state_q),
		.item  (item_s1),
		.period(period_q),
		.nxt   (state_next),
		.res   (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode             <= MODE_IDLE;
			state_q.last_reply       <= REPLY_NONE;
			state_q.line_position    <= '0;
			state_q.line_start_chars <= '0;
			state_q.recent_chars     <= '0;
			state_q.ticks_left       <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, result_s2.link_state, result_s2.timed_out,
		result_s2.publish_accepted, result_s2.message_size,
		result_s2.message_done, result_s2.tx_send};

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the serial link keep-alive supervisor
// A short table of commands runs first after reset. Several keep-alive
// periods follow, each with random reply lines, prompts, messages, ticks,
// publish and reset requests, all checked against a behavioral copy of the
// supervisor. Both stream sides idle in random bursts until the last phase.
// ----------------------------------------------------------------------------
module tb_top;
	import slks_pkg::*;

	localparam int LINE_POSITIONS  = 128;
	localparam int MAX_PUBLISH_LEN = 125;
	localparam int PHASES          = 8;
	localparam int PHASE_ITEMS     = 235;
	localparam int QUIET_LIMIT     = 1000;

	localparam logic [7:0] CHAR_K  = 8'h4B;
	localparam logic [7:0] CHAR_O  = 8'h4F;
	localparam logic [7:0] CHAR_GT = 8'h3E;
	localparam logic [7:0] CHAR_X  = 8'h78;

	typedef struct packed {
		command_t    cmd;
		logic [7:0]  rx_byte;
		logic        tx_ready;
		logic [7:0]  length;
		logic        typed;
		sup_result_t want;
	} plan_row_t;

	localparam sup_result_t NO_TYPED = '0;

	localparam plan_row_t OPENING [0:25] = '{
		'{CMD_TICK,    8'h00, 1'b1, 8'd0,   1'b1, '{SEND_HELLO, 1'b0, 8'd0, 1'b0, 1'b1,
			LINK_WAIT_KO}},
		'{CMD_RX_BYTE, CHAR_K, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_O, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_CR, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_TICK,    8'h00, 1'b0, 8'd0,   1'b1, '{SEND_NONE, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_IDLE}},
		'{CMD_PUBLISH, 8'hFF, 1'b1, 8'd255, 1'b1, '{SEND_NONE, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_IDLE}},
		'{CMD_PUBLISH, 8'h00, 1'b0, 8'd126, 1'b1, '{SEND_NONE, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_IDLE}},
		'{CMD_PUBLISH, 8'h00, 1'b0, 8'd125, 1'b1, '{SEND_NONE, 1'b0, 8'd0, 1'b1, 1'b0,
			LINK_PUBLISH}},
		'{CMD_TICK,    8'h00, 1'b1, 8'd0,   1'b1, '{SEND_PAYLOAD, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_WAIT_OK}},
		'{CMD_RX_BYTE, CHAR_O, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_K, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_LF, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_TICK,    8'h00, 1'b0, 8'd0,   1'b0, NO_TYPED},
		'{CMD_PUBLISH, 8'h00, 1'b0, 8'd0,   1'b1, '{SEND_NONE, 1'b0, 8'd0, 1'b1, 1'b0,
			LINK_PUBLISH}},
		'{CMD_TICK,    8'h00, 1'b0, 8'd0,   1'b1, '{SEND_NONE, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_IDLE}},
		'{CMD_RESET,   8'h00, 1'b0, 8'd0,   1'b1, '{SEND_NONE, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_EXIT}},
		'{CMD_TICK,    8'h00, 1'b1, 8'd0,   1'b1, '{SEND_EXIT, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_WAIT_TERM}},
		'{CMD_RX_BYTE, CHAR_GT, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_GT, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_GT, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_X, 1'b0, 8'd0, 1'b0, NO_TYPED},
		'{CMD_TICK,    8'h00, 1'b1, 8'd0,   1'b1, '{SEND_RESET, 1'b0, 8'd0, 1'b0, 1'b0,
			LINK_IDLE}},
		'{CMD_RX_BYTE, CHAR_TILDE, 1'b0, 8'd0, 1'b1, '{SEND_NONE, 1'b1, 8'd4, 1'b0, 1'b0,
			LINK_IDLE}},
		'{CMD_RX_BYTE, 8'h00, 1'b0, 8'd0,   1'b0, NO_TYPED},
		'{CMD_RX_BYTE, 8'hFF, 1'b0, 8'd0,   1'b0, NO_TYPED},
		'{CMD_RX_BYTE, CHAR_TILDE, 1'b0, 8'd0, 1'b1, '{SEND_NONE, 1'b1, 8'd2, 1'b0, 1'b0,
			LINK_IDLE}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        keepalive_period_wr;
	logic [15:0] keepalive_period_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [23:0] m_axis_tdata;

	bit          bursty = 1'b1;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int          errors = 0;
	int          items_sent = 0;
	sup_result_t pending_results [$];

	// Behavioral copy of the supervisor state.
	logic [2:0]  sv_mode;
	reply_t      sv_reply;
	logic [7:0]  sv_line_pos;
	logic [15:0] sv_first_two;
	logic [23:0] sv_last_three;
	logic [15:0] sv_ticks_left;
	logic [15:0] sv_period;

	serial_link_keepalive_supervisor u_top (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.keepalive_period_wr    (keepalive_period_wr),
		.keepalive_period_wdata (keepalive_period_wdata),
		.s_axis_tvalid          (s_axis_tvalid),
		.s_axis_tready          (s_axis_tready),
		.s_axis_tdata           (s_axis_tdata),
		.s_axis_tuser           (s_axis_tuser),
		.m_axis_tvalid          (m_axis_tvalid),
		.m_axis_tready          (m_axis_tready),
		.m_axis_tdata           (m_axis_tdata)
	);

	always #6 clk = ~clk;

	function automatic sup_result_t step_supervisor(input command_t cmd, input logic [7:0] b,
			input logic rdy, input logic [7:0] len);
		sup_result_t r;
		r = '0;
		case (cmd)
			CMD_RX_BYTE: begin
				if (b == CHAR_LF || b == CHAR_CR) begin
					if (sv_line_pos > 1) begin
						if (sv_first_two == LINE_KO)
							sv_reply = REPLY_KO;
						else if (sv_first_two == LINE_OK)
							sv_reply = REPLY_OK;
					end
					sv_line_pos = '0;
				end else if (b == CHAR_TILDE) begin
					if (sv_line_pos > 1) begin
						r.message_done = 1'b1;
						r.message_size = sv_line_pos;
					end
					sv_line_pos = '0;
				end else begin
					// The prompt check looks at the three bytes stored before this one.
					if (sv_line_pos > 2 && sv_last_three == PROMPT_TERM)
						sv_reply = REPLY_TERM;
					if (sv_line_pos == 0)
						sv_first_two = {b, 8'h00};
					else if (sv_line_pos == 1)
						sv_first_two[7:0] = b;
					sv_last_three = {sv_last_three[15:0], b};
					if (sv_line_pos >= LINE_POSITIONS)
						sv_line_pos = '0;
					else
						sv_line_pos = sv_line_pos + 8'd1;
				end
			end
			CMD_TICK: begin
				if (sv_ticks_left == 0) begin
					r.timed_out = 1'b1;
					sv_ticks_left = sv_period;
					if (sv_mode == LINK_WAIT_OK || sv_mode == LINK_WAIT_KO ||
							sv_mode == LINK_WAIT_TERM)
						sv_mode = LINK_EXIT;
					else if (sv_mode == LINK_IDLE)
						sv_mode = LINK_CHECK;
				end else begin
					sv_ticks_left = sv_ticks_left - 16'd1;
				end
				case (sv_mode)
					LINK_CHECK: if (rdy) begin
						r.tx_send = SEND_HELLO;
						sv_mode = LINK_WAIT_KO;
					end
					LINK_WAIT_KO: if (sv_reply == REPLY_KO) begin
						sv_reply = REPLY_NONE;
						sv_mode = LINK_IDLE;
					end
					LINK_WAIT_OK: if (sv_reply == REPLY_OK) begin
						sv_reply = REPLY_NONE;
						sv_mode = LINK_IDLE;
					end
					LINK_EXIT: if (rdy) begin
						r.tx_send = SEND_EXIT;
						sv_mode = LINK_WAIT_TERM;
					end
					LINK_WAIT_TERM: if (sv_reply == REPLY_TERM && rdy) begin
						r.tx_send = SEND_RESET;
						sv_mode = LINK_IDLE;
					end
					LINK_PUBLISH: begin
						if (rdy) begin
							r.tx_send = SEND_PAYLOAD;
							sv_mode = LINK_WAIT_OK;
						end else begin
							sv_mode = LINK_IDLE;
						end
					end
					default: ;
				endcase
			end
			CMD_PUBLISH: begin
				if (sv_mode == LINK_IDLE && len <= MAX_PUBLISH_LEN) begin
					sv_ticks_left = sv_period;
					sv_mode = LINK_PUBLISH;
					r.publish_accepted = 1'b1;
				end
			end
			default: sv_mode = LINK_EXIT;
		endcase
		r.link_state = sv_mode;
		return r;
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CHAR_LF || c == CHAR_CR || c == CHAR_TILDE);
		return c;
	endfunction

	task automatic send_item(input command_t cmd, input logic [7:0] b, input logic rdy,
			input logic [7:0] len);
		if (bursty && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, len, rdy, b};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(step_supervisor(cmd, b, rdy, len));
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(CMD_RX_BYTE, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	task automatic send_tick(input logic rdy);
		send_item(CMD_TICK, 8'($urandom_range(0, 255)), rdy, 8'($urandom_range(0, 255)));
	endtask

	task automatic load_period(input logic [15:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		keepalive_period_wr    <= 1'b1;
		keepalive_period_wdata <= v;
		@(posedge clk);
		keepalive_period_wr <= 1'b0;
		sv_period = v;
	endtask

	task automatic run_scenario();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			// Reply line, mostly well formed.
			if ($urandom_range(0, 1) == 0)
				send_byte(CHAR_LF);
			n = $urandom_range(0, 9);
			if (n < 4) begin
				send_byte(CHAR_O);
				send_byte(CHAR_K);
			end else if (n < 8) begin
				send_byte(CHAR_K);
				send_byte(CHAR_O);
			end else if (n == 8) begin
				send_byte($urandom_range(0, 1) ? CHAR_O : CHAR_K);
			end else begin
				send_byte(plain_char());
				send_byte(plain_char());
			end
			repeat ($urandom_range(0, 6)) send_byte(plain_char());
			send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
		end else if (pick < 35) begin
			repeat ($urandom_range(2, 4)) send_byte(CHAR_GT);
			send_byte($urandom_range(0, 3) == 0 ? CHAR_LF : plain_char());
		end else if (pick < 50) begin
			repeat ($urandom_range(0, 20)) send_byte(plain_char());
			send_byte(CHAR_TILDE);
		end else if (pick < 75) begin
			repeat ($urandom_range(1, 8)) send_tick($urandom_range(0, 3) != 0);
		end else if (pick < 85) begin
			send_item(CMD_PUBLISH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				$urandom_range(0, 4) == 0 ? 8'($urandom_range(126, 255)) :
				8'($urandom_range(0, 125)));
			repeat ($urandom_range(1, 2)) send_tick($urandom_range(0, 3) != 0);
		end else if (pick < 88) begin
			send_item(CMD_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)));
			repeat ($urandom_range(1, 3)) send_tick($urandom_range(0, 3) != 0);
		end else if (pick < 97) begin
			repeat ($urandom_range(1, 6))
				send_item(command_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		end else begin
			// Long line that may run past the last position and wrap.
			repeat ($urandom_range(125, 140)) send_byte(plain_char());
			send_byte($urandom_range(0, 1) ? CHAR_TILDE : CHAR_CR);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Receiver stalls in random bursts.
	always @(posedge clk) begin
		if (!bursty) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left    <= $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		sup_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result transaction with nothing expected, actual %h", $time,
					m_axis_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("tx_send", want.tx_send, m_axis_tdata[2:0]);
				check_field("message_done", want.message_done, m_axis_tdata[3]);
				check_field("message_size", want.message_size, m_axis_tdata[11:4]);
				check_field("publish_accepted", want.publish_accepted, m_axis_tdata[12]);
				check_field("timed_out", want.timed_out, m_axis_tdata[13]);
				check_field("link_state", want.link_state, m_axis_tdata[16:14]);
				check_field("padding", 0, m_axis_tdata[23:17]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n                 <= 1'b0;
		keepalive_period_wr    <= 1'b0;
		keepalive_period_wdata <= '0;
		s_axis_tvalid          <= 1'b0;
		s_axis_tdata           <= '0;
		s_axis_tuser           <= '0;
		sv_mode       = LINK_IDLE;
		sv_reply      = REPLY_NONE;
		sv_line_pos   = '0;
		sv_first_two  = '0;
		sv_last_three = '0;
		sv_ticks_left = '0;
		sv_period     = PERIOD_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[i]) begin
			send_item(OPENING[i].cmd, OPENING[i].rx_byte, OPENING[i].tx_ready,
				OPENING[i].length);
			if (OPENING[i].typed)
				pending_results[pending_results.size() - 1] = OPENING[i].want;
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: load_period(16'd1);
				1: load_period(16'hFFFF);
				default: load_period(16'($urandom_range(2, 60)));
			endcase
			// The last phase runs with both sides at full rate.
			if (ph == PHASES - 1)
				bursty = 1'b0;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				run_scenario();
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
